[rtl/y2r_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_pkg: shared constants and types for the YUV 4:2:0 to RGB converter
// Frame limits, counter widths, item layout and BT.601 coefficients.
// ----------------------------------------------------------------------------
package y2r_pkg;

  // Frame limits
  localparam int MAX_WIDTH  = 1280;
  localparam int MAX_HEIGHT = 800;

  // Register widths and reset values
  localparam int FW_W = 11;
  localparam int FH_W = 10;
  localparam logic [FW_W-1:0] FW_RESET = FW_W'(1280);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(800);

  // Position counters and the widths their limit compares need
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCMP_W = (FW_W > COL_W + 1) ? FW_W : COL_W + 1;
  localparam int HCMP_W = (FH_W > ROW_W + 1) ? FH_W : ROW_W + 1;

  // Chroma line store: one U/V pair per column pair
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int PIX_W      = 8;
  localparam int CHROMA_W   = 2 * PIX_W;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // Item as it passes from front to back: luma with its resolved chroma
  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic             eol;
    logic             eof;
  } pix_t;

  // Arithmetic
  localparam int PROD_W = 20;
  localparam int COEF_W = PIX_W + 1;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam int    SHIFT    = 8;
  localparam prod_t K_Y      = prod_t'(298);
  localparam prod_t K_RV     = prod_t'(409);
  localparam prod_t K_GU     = prod_t'(100);
  localparam prod_t K_GV     = prod_t'(208);
  localparam prod_t K_BU     = prod_t'(516);
  localparam prod_t K_RND    = prod_t'(128);
  localparam prod_t BYTE_MAX = prod_t'(255);
  localparam int    Y_OFS    = 16;
  localparam int    C_OFS    = 128;

endpackage
`default_nettype wire

[rtl/y2r_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module y2r_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 640,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/y2r_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_front: raster tracking and chroma upsampling
// Counts columns and rows, keeps the chroma line store and holding register,
// and hands each item with its resolved chroma to the queue.
// ----------------------------------------------------------------------------
module y2r_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [y2r_pkg::FW_W-1:0] frame_width,
  input  wire logic [y2r_pkg::FH_W-1:0] frame_height,
  input  wire logic                     in_push,
  output logic                          in_full,
  input  wire logic [7:0]               in_luma,
  input  wire logic [7:0]               in_chroma_blue,
  input  wire logic [7:0]               in_chroma_red,
  output logic                          q_push,
  input  wire logic                     q_full,
  output y2r_pkg::pix_t                 q_data
);

  typedef enum logic [1:0] {
    SRC_NEW,
    SRC_LINE,
    SRC_HELD
  } src_t;

  logic [y2r_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [y2r_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic                         fb_vld_r, fb_vld_nxt;
  logic [y2r_pkg::CHROMA_W-1:0] held_r, held_nxt;

  logic [y2r_pkg::PIX_W-1:0]    fb_luma_r;
  logic [y2r_pkg::CHROMA_W-1:0] fb_uv_r;
  src_t                         fb_src_r;
  logic                         fb_eol_r;
  logic                         fb_eof_r;

  logic [y2r_pkg::WCMP_W-1:0]   w_lim, w_eff;
  logic [y2r_pkg::HCMP_W-1:0]   h_lim, h_eff;
  logic                         eol, eof;
  logic                         accept;
  logic                         odd_col, odd_row;
  logic [y2r_pkg::SLOT_W-1:0]   slot;
  logic                         ram_we, ram_re;
  logic [y2r_pkg::CHROMA_W-1:0] ram_rdata;
  logic [y2r_pkg::CHROMA_W-1:0] chroma_sel;

  // Effective frame size, clamped to 1..max
  always_comb begin
    w_lim = y2r_pkg::WCMP_W'(frame_width);
    h_lim = y2r_pkg::HCMP_W'(frame_height);
    if (frame_width == '0) begin
      w_eff = y2r_pkg::WCMP_W'(1);
    end else if (w_lim > y2r_pkg::WCMP_W'(y2r_pkg::MAX_WIDTH)) begin
      w_eff = y2r_pkg::WCMP_W'(y2r_pkg::MAX_WIDTH);
    end else begin
      w_eff = w_lim;
    end
    if (frame_height == '0) begin
      h_eff = y2r_pkg::HCMP_W'(1);
    end else if (h_lim > y2r_pkg::HCMP_W'(y2r_pkg::MAX_HEIGHT)) begin
      h_eff = y2r_pkg::HCMP_W'(y2r_pkg::MAX_HEIGHT);
    end else begin
      h_eff = h_lim;
    end
  end

  assign eol = (y2r_pkg::WCMP_W'(col_r) + y2r_pkg::WCMP_W'(1)) >= w_eff;
  assign eof = eol && ((y2r_pkg::HCMP_W'(row_r) + y2r_pkg::HCMP_W'(1)) >= h_eff);

  assign odd_col = col_r[0];
  assign odd_row = row_r[0];
  assign slot    = y2r_pkg::SLOT_W'(col_r >> 1);

  assign in_full = fb_vld_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = fb_vld_r && !q_full;

  // Even row writes the line, odd row reads it back at the quad's first column
  assign ram_we = accept && !odd_col && !odd_row;
  assign ram_re = accept && !odd_col && odd_row;

  y2r_ram #(
    .WIDTH (y2r_pkg::CHROMA_W),
    .DEPTH (y2r_pkg::LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot),
    .wr_data ({in_chroma_blue, in_chroma_red}),
    .rd_en   (ram_re),
    .rd_addr (slot),
    .rd_data (ram_rdata)
  );

  always_comb begin
    case (fb_src_r)
      SRC_NEW:  chroma_sel = fb_uv_r;
      SRC_LINE: chroma_sel = ram_rdata;
      default:  chroma_sel = held_r;
    endcase
  end

  assign q_data = '{
    luma: fb_luma_r,
    cb:   chroma_sel[y2r_pkg::CHROMA_W-1:y2r_pkg::PIX_W],
    cr:   chroma_sel[y2r_pkg::PIX_W-1:0],
    eol:  fb_eol_r,
    eof:  fb_eof_r
  };

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    fb_vld_nxt = fb_vld_r;
    held_nxt   = held_r;
    // held chroma follows item order, so update it as the item leaves
    if (q_push) begin
      fb_vld_nxt = 1'b0;
      if (fb_src_r != SRC_HELD) begin
        held_nxt = chroma_sel;
      end
    end
    if (accept) begin
      fb_vld_nxt = 1'b1;
      if (eol) begin
        col_nxt = '0;
        row_nxt = eof ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      fb_vld_r <= 1'b0;
      held_r   <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      fb_vld_r <= fb_vld_nxt;
      held_r   <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fb_luma_r <= in_luma;
      fb_uv_r   <= {in_chroma_blue, in_chroma_red};
      fb_src_r  <= odd_col ? SRC_HELD : (odd_row ? SRC_LINE : SRC_NEW);
      fb_eol_r  <= eol;
      fb_eof_r  <= eof;
    end
  end

`ifndef SYNTHESIS
  a_ram_one_op : assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("line store written and read by the same item");

  a_col_range : assert property (@(posedge clk) disable iff (!rst_n)
    col_r < y2r_pkg::COL_W'(y2r_pkg::MAX_WIDTH))
    else $error("column counter beyond maximum width");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (fb_vld_r && q_full) |=> (fb_vld_r && $stable(fb_luma_r) && $stable(fb_src_r)))
    else $error("stalled front item lost or changed");
`endif

endmodule
`default_nettype wire

[rtl/y2r_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_fifo: short item queue between front and back
// Register-based FIFO, combinational read of the oldest entry.
// ----------------------------------------------------------------------------
module y2r_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  output logic               full,
  input  wire y2r_pkg::pix_t wr_data,
  input  wire logic          rd_en,
  output logic               empty,
  output y2r_pkg::pix_t      rd_data
);

  y2r_pkg::pix_t              mem_r [y2r_pkg::FIFO_DEPTH];
  logic [y2r_pkg::PTR_W:0]    wr_ptr_r, wr_ptr_nxt;
  logic [y2r_pkg::PTR_W:0]    rd_ptr_r, rd_ptr_nxt;
  logic                       do_wr, do_rd;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[y2r_pkg::PTR_W] != rd_ptr_r[y2r_pkg::PTR_W]) &&
                 (wr_ptr_r[y2r_pkg::PTR_W-1:0] == rd_ptr_r[y2r_pkg::PTR_W-1:0]);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  assign rd_data = mem_r[rd_ptr_r[y2r_pkg::PTR_W-1:0]];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r[y2r_pkg::PTR_W-1:0]] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_level : assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) <= (y2r_pkg::PTR_W + 1)'(y2r_pkg::FIFO_DEPTH))
    else $error("queue level beyond depth");
`endif

endmodule
`default_nettype wire

[rtl/y2r_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_back: BT.601 colour conversion
// Stage one forms the coefficient products, stage two sums, rounds and
// clamps into the output register.
// ----------------------------------------------------------------------------
module y2r_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_empty,
  input  wire y2r_pkg::pix_t              q_data,
  output logic                            q_pop,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic                            out_end_of_line,
  output logic                            out_end_of_frame,
  output logic                            out_empty,
  input  wire logic                       out_pop
);

  localparam int CW = y2r_pkg::COEF_W;

  logic signed [CW-1:0] c, d, e;
  y2r_pkg::prod_t       p_y_nxt, p_rv_nxt, p_gu_nxt, p_gv_nxt, p_bu_nxt;
  y2r_pkg::prod_t       p_y_r, p_rv_r, p_gu_r, p_gv_r, p_bu_r;
  logic                 s1_eol_r, s1_eof_r;
  logic                 s1_vld_r, s1_vld_nxt;
  logic                 s1_ready;
  y2r_pkg::prod_t       r_sum, g_sum, b_sum;
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_ready;

  function automatic logic [7:0] clamp_byte(input y2r_pkg::prod_t s);
    y2r_pkg::prod_t q;
    q = s >>> y2r_pkg::SHIFT;
    if (s < 0) begin
      return '0;
    end else if (q > y2r_pkg::BYTE_MAX) begin
      return 8'hFF;
    end else begin
      return q[7:0];
    end
  endfunction

  assign out_ready = !out_vld_r || out_pop;
  assign s1_ready  = !s1_vld_r || out_ready;
  assign q_pop     = !q_empty && s1_ready;

  always_comb begin
    c = CW'({1'b0, q_data.luma}) - CW'(y2r_pkg::Y_OFS);
    d = CW'({1'b0, q_data.cb})   - CW'(y2r_pkg::C_OFS);
    e = CW'({1'b0, q_data.cr})   - CW'(y2r_pkg::C_OFS);
    p_y_nxt  = y2r_pkg::prod_t'(c) * y2r_pkg::K_Y;
    p_rv_nxt = y2r_pkg::prod_t'(e) * y2r_pkg::K_RV;
    p_gu_nxt = y2r_pkg::prod_t'(d) * y2r_pkg::K_GU;
    p_gv_nxt = y2r_pkg::prod_t'(e) * y2r_pkg::K_GV;
    p_bu_nxt = y2r_pkg::prod_t'(d) * y2r_pkg::K_BU;
  end

  always_comb begin
    r_sum = p_y_r + p_rv_r + y2r_pkg::K_RND;
    g_sum = p_y_r - p_gu_r - p_gv_r + y2r_pkg::K_RND;
    b_sum = p_y_r + p_bu_r + y2r_pkg::K_RND;
  end

  always_comb begin
    s1_vld_nxt  = s1_ready ? !q_empty : s1_vld_r;
    out_vld_nxt = out_ready ? s1_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_y_r    <= p_y_nxt;
      p_rv_r   <= p_rv_nxt;
      p_gu_r   <= p_gu_nxt;
      p_gv_r   <= p_gv_nxt;
      p_bu_r   <= p_bu_nxt;
      s1_eol_r <= q_data.eol;
      s1_eof_r <= q_data.eof;
    end
    if (s1_vld_r && out_ready) begin
      out_red          <= clamp_byte(r_sum);
      out_green        <= clamp_byte(g_sum);
      out_blue         <= clamp_byte(b_sum);
      out_end_of_line  <= s1_eol_r;
      out_end_of_frame <= s1_eof_r;
    end
  end

  assign out_empty = !out_vld_r;

`ifndef SYNTHESIS
  a_eof_has_eol : assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (!s1_eof_r || s1_eol_r))
    else $error("end of frame without end of line");

  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !out_ready) |=> (s1_vld_r && $stable(p_y_r)))
    else $error("stalled product stage lost its item");
`endif

endmodule
`default_nettype wire

[rtl/yuv420_to_rgb_bt601.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuv420_to_rgb_bt601: YUV 4:2:0 raster to RGB converter, BT.601 studio swing
// Nearest-neighbour chroma upsampling from a line store, integer conversion
// and clamping, with end-of-line and end-of-frame marks.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------
//  in_      | to block  | push / full        | luma, chroma_blue, chroma_red
//  out_     | from block| empty / pop        | red, green, blue, eol, eof
//  cfg      | to block  | APB psel/penable   | frame_width @0, frame_height @4
//
//  One item per clock when neither side stalls.
//  A result passes through the front register (line-store read), the queue and
//  the product stage, then sum and clamp load the output register.
//  Synchronous active-low reset; the line store is not cleared, no sweep.
//  Front and back stall separately behind a four-entry queue.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_bt601 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_luma,
  input  wire logic [7:0]  in_chroma_blue,
  input  wire logic [7:0]  in_chroma_red,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_end_of_line,
  output logic             out_end_of_frame,
  output logic             out_empty,
  input  wire logic        out_pop,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  logic [y2r_pkg::FW_W-1:0] frame_width_r, frame_width_nxt;
  logic [y2r_pkg::FH_W-1:0] frame_height_r, frame_height_nxt;
  logic                     cfg_wr;

  logic                     q_push, q_full, q_pop, q_empty;
  y2r_pkg::pix_t            q_wdata, q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_nxt  = pwdata[y2r_pkg::FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = pwdata[y2r_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = 32'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= y2r_pkg::FW_RESET;
      frame_height_r <= y2r_pkg::FH_RESET;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  y2r_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .frame_width    (frame_width_r),
    .frame_height   (frame_height_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_luma        (in_luma),
    .in_chroma_blue (in_chroma_blue),
    .in_chroma_red  (in_chroma_red),
    .q_push         (q_push),
    .q_full         (q_full),
    .q_data         (q_wdata)
  );

  y2r_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .full    (q_full),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .empty   (q_empty),
    .rd_data (q_rdata)
  );

  y2r_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame),
    .out_empty        (out_empty),
    .out_pop          (out_pop)
  );

endmodule
`default_nettype wire

[tb/tb_yuv420_to_rgb_bt601.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuv420_to_rgb_bt601: self-checking bench for the YUV 4:2:0 to RGB block
// Drives luma/chroma items through the push/full side and pops RGB items with
// random stalls on both sides. A cycle-free model of the raster counters, the
// chroma line store and the BT.601 arithmetic predicts every item; frame sizes
// are reprogrammed between phases, including out-of-range and mid-frame values.
// ----------------------------------------------------------------------------
module tb_yuv420_to_rgb_bt601;

  localparam logic [2:0] ADDR_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_FRAME_HEIGHT = 3'd4;
  localparam int RESET_CYCLES   = 11;
  localparam int HOLD_CYCLES    = 64;
  localparam int TAIL_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       end_of_line;
    logic       end_of_frame;
  } rgb_px_t;

  typedef struct packed {
    logic [7:0]  luma;
    logic [7:0]  cb;
    logic [7:0]  cr;
    logic        typed;
    logic [23:0] rgb;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_luma;
  logic [7:0]  in_chroma_blue;
  logic [7:0]  in_chroma_red;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_end_of_line;
  logic        out_end_of_frame;
  logic        out_empty;
  logic        out_pop;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // typed-in colour for directed items, travels alongside the pushed item
  logic        typed_en;
  logic [23:0] typed_rgb;

  // converter state as seen by the bench
  logic [y2r_pkg::FW_W-1:0] frame_width_q  = y2r_pkg::FW_RESET;
  logic [y2r_pkg::FH_W-1:0] frame_height_q = y2r_pkg::FH_RESET;
  int              col_q = 0;
  int              row_q = 0;
  logic [15:0]     held_q = 16'h0;
  logic [15:0]     chroma_line_q [y2r_pkg::LINE_DEPTH];
  bit              slot_written [y2r_pkg::LINE_DEPTH];

  rgb_px_t pending_px [$];
  rgb_px_t predicted;
  rgb_px_t oldest;
  int      fail_count  = 0;
  int      idle_cycles = 0;
  bit      hold_req    = 1'b0;

  // 4x2 frames, two of them
  stim_row_t directed_rows [16] = '{
    '{8'd16,  8'd128, 8'd128, 1'b1, 24'h000000},
    '{8'd235, 8'd7,   8'd99,  1'b1, 24'hFFFFFF},
    '{8'd0,   8'd0,   8'd0,   1'b0, 24'h0},
    '{8'd255, 8'd200, 8'd50,  1'b0, 24'h0},
    '{8'd255, 8'd255, 8'd0,   1'b1, 24'hFFFFFF},
    '{8'd0,   8'd0,   8'd255, 1'b1, 24'h000000},
    '{8'd128, 8'd60,  8'd60,  1'b0, 24'h0},
    '{8'd16,  8'd1,   8'd2,   1'b0, 24'h0},
    '{8'd255, 8'd255, 8'd255, 1'b0, 24'h0},
    '{8'd0,   8'd255, 8'd255, 1'b0, 24'h0},
    '{8'd128, 8'd255, 8'd0,   1'b0, 24'h0},
    '{8'd200, 8'd0,   8'd255, 1'b0, 24'h0},
    '{8'd81,  8'd90,  8'd240, 1'b0, 24'h0},
    '{8'd145, 8'd54,  8'd34,  1'b0, 24'h0},
    '{8'd41,  8'd240, 8'd110, 1'b0, 24'h0},
    '{8'd235, 8'd128, 8'd128, 1'b0, 24'h0}
  };

  yuv420_to_rgb_bt601 i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_luma          (in_luma),
    .in_chroma_blue   (in_chroma_blue),
    .in_chroma_red    (in_chroma_red),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int fit_dim(input int v, input int hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [7:0] to_byte(input int sum);
    if (sum < 0) return 8'd0;
    if ((sum >>> 8) > 255) return 8'd255;
    return 8'(sum >>> 8);
  endfunction

  // Convert one pixel and advance the raster position.
  function automatic rgb_px_t convert_next(input logic [7:0] y, input logic [7:0] cb_in,
                                           input logic [7:0] cr_in);
    rgb_px_t px;
    int w, h, slot, c, d, e;
    w = fit_dim(frame_width_q, y2r_pkg::MAX_WIDTH);
    h = fit_dim(frame_height_q, y2r_pkg::MAX_HEIGHT);
    slot = col_q >> 1;
    if (col_q % 2 == 0) begin
      if (row_q % 2 == 0) begin
        held_q = {cb_in, cr_in};
        if (slot < y2r_pkg::LINE_DEPTH) begin
          chroma_line_q[slot] = held_q;
          slot_written[slot] = 1'b1;
        end
      end else begin
        held_q = (slot < y2r_pkg::LINE_DEPTH) ? chroma_line_q[slot] : 16'h0;
      end
    end
    c = int'(y) - 16;
    d = int'(held_q[15:8]) - 128;
    e = int'(held_q[7:0]) - 128;
    px.red   = to_byte(298 * c + 409 * e + 128);
    px.green = to_byte(298 * c - 100 * d - 208 * e + 128);
    px.blue  = to_byte(298 * c + 516 * d + 128);
    px.end_of_line  = (col_q >= w - 1);
    px.end_of_frame = px.end_of_line && (row_q >= h - 1);
    if (px.end_of_line) begin
      col_q = 0;
      row_q = px.end_of_frame ? 0 : row_q + 1;
    end else begin
      col_q = col_q + 1;
    end
    return px;
  endfunction

  // On an odd row every slot still to be read at width w must hold chroma.
  function automatic bit line_ready(input int w);
    int hi;
    hi = ((col_q > w - 1) ? col_q : w - 1) >> 1;
    for (int s = col_q >> 1; s <= hi; s++) begin
      if (s < y2r_pkg::LINE_DEPTH && !slot_written[s]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Narrow a requested width until no unwritten chroma slot can be read.
  function automatic logic [y2r_pkg::FW_W-1:0] safe_width(
      input logic [y2r_pkg::FW_W-1:0] req);
    int w;
    w = fit_dim(req, y2r_pkg::MAX_WIDTH);
    if (row_q % 2 == 0 || line_ready(w)) return req;
    while (w > 1 && !line_ready(w)) w--;
    return y2r_pkg::FW_W'(w);
  endfunction

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd16;
      3:       return 8'd235;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  task automatic next_gap(inout int calm, output int gap);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else begin
      if (r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 80);
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Called and returns at a falling edge, after the bus has gone idle following the access.
  task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] data,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input logic [2:0] addr, input logic [31:0] exp_v);
    logic [31:0] rd;
    apb_xfer(1'b0, addr, 32'h0, rd);
    check_field((addr == ADDR_FRAME_WIDTH) ? "frame_width" : "frame_height", exp_v, rd);
  endtask

  task automatic set_reg(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, addr, value, rd);
    check_reg(addr, value);
  endtask

  // Called and returns at a falling edge; push stays high for a following item.
  task automatic send_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr,
                            input bit typed, input logic [23:0] rgb);
    static int calm = 0;
    int gap;
    next_gap(calm, gap);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push        <= 1'b1;
    in_luma        <= y;
    in_chroma_blue <= cb;
    in_chroma_red  <= cr;
    typed_en       <= typed;
    typed_rgb      <= rgb;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending_px.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int w, input int h, input int n, input bit hold);
    drain();
    set_reg(ADDR_FRAME_HEIGHT, h);
    set_reg(ADDR_FRAME_WIDTH, safe_width(y2r_pkg::FW_W'(w)));
    hold_req = hold;
    for (int k = 0; k < n; k++)
      send_pixel(rand_sample(), rand_sample(), rand_sample(), 1'b0, 24'h0);
    in_push <= 1'b0;
  endtask

  // Monitor: predict on every accepted item, compare every popped one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_FRAME_WIDTH:  frame_width_q  = pwdata[y2r_pkg::FW_W-1:0];
          ADDR_FRAME_HEIGHT: frame_height_q = pwdata[y2r_pkg::FH_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        predicted = convert_next(in_luma, in_chroma_blue, in_chroma_red);
        if (typed_en) {predicted.red, predicted.green, predicted.blue} = typed_rgb;
        pending_px.push_back(predicted);
      end
      if (out_pop && !out_empty) begin
        if (pending_px.size() == 0) begin
          $error("unexpected item: rgb %0d %0d %0d", out_red, out_green, out_blue);
          fail_count++;
        end else begin
          oldest = pending_px.pop_front();
          check_field("red", oldest.red, out_red);
          check_field("green", oldest.green, out_green);
          check_field("blue", oldest.blue, out_blue);
          check_field("end_of_line", oldest.end_of_line, out_end_of_line);
          check_field("end_of_frame", oldest.end_of_frame, out_end_of_frame);
        end
      end
    end
    if ((in_push && !in_full) || (out_pop && !out_empty) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    static int calm = 0;
    int stall;
    stall = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        next_gap(calm, stall);
        out_pop <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_luma        = 8'h0;
    in_chroma_blue = 8'h0;
    in_chroma_red  = 8'h0;
    typed_en       = 1'b0;
    typed_rgb      = 24'h0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = ADDR_FRAME_WIDTH;
    pwdata         = 32'h0;
    foreach (slot_written[s]) slot_written[s] = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    check_reg(ADDR_FRAME_WIDTH, y2r_pkg::FW_RESET);
    check_reg(ADDR_FRAME_HEIGHT, y2r_pkg::FH_RESET);
    set_reg(ADDR_FRAME_WIDTH, 4);
    set_reg(ADDR_FRAME_HEIGHT, 2);
    foreach (directed_rows[i])
      send_pixel(directed_rows[i].luma, directed_rows[i].cb, directed_rows[i].cr,
                 directed_rows[i].typed, directed_rows[i].rgb);
    in_push <= 1'b0;

    run_phase(1, 1, 40, 1'b0);        // every item closes a frame
    run_phase(0, 0, 30, 1'b0);        // zero sizes clamp up to one
    run_phase(3, 5, 119, 1'b1);       // odd width; result side held off to fill the block
    run_phase(6, 5, 80, 1'b0);        // change width mid-frame, counters keep going
    run_phase(2047, 1, 1280, 1'b0);   // oversize width clamps to the full line
    run_phase(2, 1023, 200, 1'b0);    // oversize height clamps, never reached
    run_phase(1280, 800, 60, 1'b0);
    run_phase(5, 3, 100, 1'b0);
    run_phase(7, 2, 40, 1'b1);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/y2r_pkg.sv
rtl/y2r_ram.sv
rtl/y2r_front.sv
rtl/y2r_fifo.sv
rtl/y2r_back.sv
rtl/yuv420_to_rgb_bt601.sv
tb/tb_yuv420_to_rgb_bt601.sv
